// File: rtl/core/patp_pkg.sv
// ----------------------------------------------------------------------------
// patp_pkg: shared types and constants of the pitch arc target unit
// Formats, CORDIC constants, register indexes and inter-stage records.
// ----------------------------------------------------------------------------
`default_nettype none
package patp_pkg;

  localparam int CordicStages = 18;
  localparam int CordicN = (CordicStages > 24) ? 24 : CordicStages;
  localparam int CW = 42;

  localparam logic signed [19:0] PiQ16 = 20'sd205887;
  localparam logic signed [20:0] TwoPiQ16 = 21'sd411775;
  localparam logic signed [27:0] PiQ24 = 28'sd52707179;
  localparam logic signed [27:0] HalfPiQ24 = 28'sd26353589;
  localparam logic signed [31:0] GainQ30 = 32'sd652032874;

  typedef enum logic [2:0] {
    REG_PIVOT_X    = 3'd0,
    REG_PIVOT_Z    = 3'd1,
    REG_RADIUS_X   = 3'd2,
    REG_RADIUS_Z   = 3'd3,
    REG_REF_PITCH  = 3'd4,
    REG_MAX_DELTA  = 3'd5,
    REG_NEGATE     = 3'd6,
    REG_MIN_RADIUS = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [23:0] pivot_x;
    logic signed [23:0] pivot_z;
    logic signed [23:0] radius_x;
    logic signed [23:0] radius_z;
    logic signed [18:0] ref_pitch;
    logic [17:0] max_delta;
    logic negate_pitch;
    logic [22:0] min_radius;
  } cfg_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] z;
    logic signed [27:0] ang;
  } cvec_t;

  typedef struct packed {
    logic signed [23:0] pos_y;
    logic signed [18:0] pitch;
    logic ok;
  } side_t;

  function automatic logic signed [27:0] atan_q24(input int i);
    logic signed [27:0] t;
    begin
      unique case (i)
        0: t = 28'sd13176795;
        1: t = 28'sd7778716;
        2: t = 28'sd4110060;
        3: t = 28'sd2086331;
        4: t = 28'sd1047214;
        5: t = 28'sd524117;
        6: t = 28'sd262123;
        7: t = 28'sd131069;
        default: t = 28'sd65536 >>> (i - 8);
      endcase
      return t;
    end
  endfunction

  function automatic logic signed [20:0] wrap_pi(input logic signed [20:0] a);
    logic signed [20:0] r;
    begin
      r = a;
      if (r > 21'(PiQ16)) r = r - TwoPiQ16;
      else if (r < -21'(PiQ16)) r = r + TwoPiQ16;
      return r;
    end
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [CW:0] v);
    begin
      if (v > 43'sd8388607) return 24'sh7FFFFF;
      if (v < -43'sd8388608) return 24'sh800000;
      return v[23:0];
    end
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/pivot_arc_target_from_pitch_unit.sv
// ----------------------------------------------------------------------------
// pivot_arc_target_from_pitch_unit: pitch-driven arc target generator
// Usage:
//   Slave stream in_*: one request per target. in_tdata from bit 0 up:
//   nav_pitch[19], pitch_offset[19], target_y[24], branch_offset[24].
//   Master stream out_*: one result per request. out_tdata from bit 0 up:
//   pos_x[24], pos_y[24], pos_z[24], out_pitch[19], valid_res[1].
//   Config port cfg_*: write cfg_wdata to register cfg_addr while idle.
// One request is accepted every cycle in which the pipeline advances, and
// the pipeline advances as a whole: it moves whenever the output register
// is empty or being taken, so in_tready follows out_tready or an empty
// output slot.
// Reset clears all valid bits and loads register defaults; items in flight are dropped.
// ----------------------------------------------------------------------------
`default_nettype none
module pivot_arc_target_from_pitch_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [87:0]  in_tdata,  // nav_pitch, pitch_offset, target_y, branch_offset
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [95:0]       out_tdata, // pos_x, pos_y, pos_z, out_pitch, valid_res
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [23:0]  cfg_wdata
);
  import patp_pkg::*;

  cfg_t cfg_r;
  logic en;
  logic fv, cv;
  cvec_t fvec, cvec;
  side_t fside, cside;
  logic ov_r;
  logic [95:0] od_r;
  logic signed [CW:0] rx, rz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{pivot_x: '0, pivot_z: '0, radius_x: '0, radius_z: '0, ref_pitch: '0,
                 max_delta: 18'd51472, negate_pitch: 1'b0, min_radius: 23'd3277};
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_PIVOT_X:    cfg_r.pivot_x <= cfg_wdata;
        REG_PIVOT_Z:    cfg_r.pivot_z <= cfg_wdata;
        REG_RADIUS_X:   cfg_r.radius_x <= cfg_wdata;
        REG_RADIUS_Z:   cfg_r.radius_z <= cfg_wdata;
        REG_REF_PITCH:  cfg_r.ref_pitch <= cfg_wdata[18:0];
        REG_MAX_DELTA:  cfg_r.max_delta <= cfg_wdata[17:0];
        REG_NEGATE:     cfg_r.negate_pitch <= cfg_wdata[0];
        REG_MIN_RADIUS: cfg_r.min_radius <= cfg_wdata[22:0];
        default: ;
      endcase
    end
  end

  assign en = !ov_r || out_tready;
  assign in_tready = en;

  patp_front u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(in_tvalid && en), .cfg(cfg_r),
    .nav_pitch(in_tdata[18:0]), .pitch_offset(in_tdata[37:19]),
    .target_y(in_tdata[61:38]), .branch_offset(in_tdata[85:62]),
    .out_v(fv), .vec(fvec), .side(fside)
  );

  patp_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(fv), .in_vec(fvec),
    .in_side(fside), .out_v(cv), .out_vec(cvec), .out_side(cside)
  );

  always_comb begin
    rx = (CW+1)'(cfg_r.pivot_x) + (CW+1)'((cvec.x + CW'(8192)) >>> 14);
    rz = (CW+1)'(cfg_r.pivot_z) + (CW+1)'((cvec.z + CW'(8192)) >>> 14);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (en) ov_r <= cv;
    if (en) begin
      if (cside.ok) od_r <= {4'd0, 1'b1, cside.pitch, sat24(rz), cside.pos_y, sat24(rx)};
      else od_r <= '0;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata = od_r;
endmodule
`default_nettype wire

// File: rtl/core/patp_front.sv
// ----------------------------------------------------------------------------
// patp_front: angle and radius preparation
// Wraps pitch, clamps delta, scales radius by CORDIC gain, checks min radius.
// ----------------------------------------------------------------------------
`default_nettype none
module patp_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  in_v,
  input  wire patp_pkg::cfg_t        cfg,
  input  wire logic signed [18:0]    nav_pitch,
  input  wire logic signed [18:0]    pitch_offset,
  input  wire logic signed [23:0]    target_y,
  input  wire logic signed [23:0]    branch_offset,
  output logic                       out_v,
  output patp_pkg::cvec_t            vec,
  output patp_pkg::side_t            side
);
  import patp_pkg::*;

  logic v1_r, v2_r, v3_r;
  logic signed [20:0] tgt1_r;
  logic signed [24:0] y1_r;
  logic signed [47:0] rxx1_r, rzz1_r;
  logic [45:0] mm1_r;
  logic signed [18:0] tgt2_r, tgt3_r;
  logic signed [24:0] y2_r, y3_r;
  logic ok2_r, ok3_r;
  logic signed [27:0] ang2_r, ang3_r;
  logic signed [55:0] px2_r, pz2_r;
  logic signed [CW-1:0] cx3_r, cz3_r;

  logic signed [20:0] delta, md;
  logic signed [27:0] ang_nxt;
  logic signed [CW-1:0] cx, cz;

  always_comb begin
    delta = wrap_pi(21'(tgt1_r) - 21'(cfg.ref_pitch));
    md = 21'($signed({1'b0, cfg.max_delta}));
    if (delta < -md) delta = -md;
    if (delta > md) delta = md;
    if (cfg.negate_pitch) delta = -delta;
    ang_nxt = 28'(delta) <<< 8;
    cx = CW'(px2_r >>> 16);
    cz = CW'(pz2_r >>> 16);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    if (en) begin
      tgt1_r <= wrap_pi(21'(nav_pitch) + 21'(pitch_offset));
      y1_r <= 25'(target_y) + 25'(branch_offset);
      rxx1_r <= cfg.radius_x * cfg.radius_x;
      rzz1_r <= cfg.radius_z * cfg.radius_z;
      mm1_r <= cfg.min_radius * cfg.min_radius;
      tgt2_r <= tgt1_r[18:0];
      y2_r <= y1_r;
      ok2_r <= ({1'b0, rxx1_r} + {1'b0, rzz1_r}) >= 49'(mm1_r);
      ang2_r <= ang_nxt;
      px2_r <= cfg.radius_x * GainQ30;
      pz2_r <= cfg.radius_z * GainQ30;
      tgt3_r <= tgt2_r;
      y3_r <= y2_r;
      ok3_r <= ok2_r;
      if (ang2_r > HalfPiQ24) begin
        ang3_r <= ang2_r - PiQ24;
        cx3_r <= -cx;
        cz3_r <= -cz;
      end else if (ang2_r < -HalfPiQ24) begin
        ang3_r <= ang2_r + PiQ24;
        cx3_r <= -cx;
        cz3_r <= -cz;
      end else begin
        ang3_r <= ang2_r;
        cx3_r <= cx;
        cz3_r <= cz;
      end
    end
  end

  always_comb begin
    out_v = v3_r;
    vec.x = cx3_r;
    vec.z = cz3_r;
    vec.ang = ang3_r;
    side.ok = ok3_r;
    side.pitch = tgt3_r;
    side.pos_y = sat24(43'(y3_r));
  end
endmodule
`default_nettype wire

// File: rtl/core/patp_cordic.sv
// ----------------------------------------------------------------------------
// patp_cordic: pipelined CORDIC rotator
// One micro-rotation per register stage, side data carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none
module patp_cordic (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_v,
  input  wire patp_pkg::cvec_t  in_vec,
  input  wire patp_pkg::side_t  in_side,
  output logic                  out_v,
  output patp_pkg::cvec_t       out_vec,
  output patp_pkg::side_t       out_side
);
  import patp_pkg::*;

  cvec_t vec_r [CordicN+1];
  side_t side_r [CordicN+1];
  logic [CordicN:0] v_r;

  always_comb begin
    vec_r[0] = in_vec;
    side_r[0] = in_side;
    v_r[0] = in_v;
  end

  for (genvar i = 0; i < CordicN; i++) begin : g_stage
    cvec_t nxt;
    always_comb begin
      nxt = vec_r[i];
      if (vec_r[i].ang >= 0) begin
        nxt.z = vec_r[i].z - (vec_r[i].x >>> i);
        nxt.x = vec_r[i].x + (vec_r[i].z >>> i);
        nxt.ang = vec_r[i].ang - atan_q24(i);
      end else begin
        nxt.z = vec_r[i].z + (vec_r[i].x >>> i);
        nxt.x = vec_r[i].x - (vec_r[i].z >>> i);
        nxt.ang = vec_r[i].ang + atan_q24(i);
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[i+1] <= 1'b0;
      else if (en) v_r[i+1] <= v_r[i];
      if (en) begin
        vec_r[i+1] <= nxt;
        side_r[i+1] <= side_r[i];
      end
    end
  end

  always_comb begin
    out_v = v_r[CordicN];
    out_vec = vec_r[CordicN];
    out_side = side_r[CordicN];
  end
endmodule
`default_nettype wire

// File: tb/pivot_arc_target_from_pitch_unit_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pivot_arc_target_from_pitch_unit_check: result checker for the arc unit
// Watches the config port and both streams, keeps its own register copy,
// predicts each arc target from the accepted request and compares the
// results in order, field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module pivot_arc_target_from_pitch_unit_check (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [87:0] in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [95:0] out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [23:0] cfg_wdata,
  output int               pending,
  output int               errors
);
  import patp_pkg::*;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [18:0] pitch;
    logic               ok;
  } arc_t;

  cfg_t regs;
  arc_t arc_queue[$];

  function automatic longint wrap_angle(input longint a);
    longint r;
    r = a;
    while (r > 205887) r = r - 411775;
    while (r < -205887) r = r + 411775;
    return r;
  endfunction

  function automatic logic signed [23:0] clip24(input longint v);
    if (v > 8388607) return 24'sh7FFFFF;
    if (v < -8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic arc_t predict_arc(input logic [87:0] d);
    longint nom, offs, ty, boff, rx, rz, minr, md, target, delta, ang, cx, cz, sx, sz;
    longint atab[24];
    arc_t r;
    atab = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
             65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
             256, 128, 64, 32, 16, 8, 4, 2};
    nom = longint'($signed(d[18:0]));
    offs = longint'($signed(d[37:19]));
    ty = longint'($signed(d[61:38]));
    boff = longint'($signed(d[85:62]));
    rx = longint'(regs.radius_x);
    rz = longint'(regs.radius_z);
    minr = longint'(regs.min_radius);
    md = longint'(regs.max_delta);
    r = '0;
    if (rx * rx + rz * rz < minr * minr) return r;
    target = wrap_angle(nom + offs);
    delta = wrap_angle(target - longint'(regs.ref_pitch));
    if (delta < -md) delta = -md;
    if (delta > md) delta = md;
    if (regs.negate_pitch) delta = -delta;
    ang = delta * 256;
    cx = (rx * 652032874) >>> 16;
    cz = (rz * 652032874) >>> 16;
    if (ang > 26353589) begin
      ang = ang - 52707179; cx = -cx; cz = -cz;
    end else if (ang < -26353589) begin
      ang = ang + 52707179; cx = -cx; cz = -cz;
    end
    for (int i = 0; i < CordicN; i++) begin
      sz = cx >>> i;
      sx = cz >>> i;
      if (ang >= 0) begin
        cz = cz - sz; cx = cx + sx; ang = ang - atab[i];
      end else begin
        cz = cz + sz; cx = cx - sx; ang = ang + atab[i];
      end
    end
    r.pos_x = clip24(longint'(regs.pivot_x) + ((cx + 8192) >>> 14));
    r.pos_y = clip24(ty + boff);
    r.pos_z = clip24(longint'(regs.pivot_z) + ((cz + 8192) >>> 14));
    r.pitch = target[18:0];
    r.ok = 1'b1;
    return r;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  initial errors = 0;
  assign pending = arc_queue.size();

  always @(posedge clk) begin
    arc_t got, want;
    if (!rst_n) begin
      regs <= '{pivot_x: '0, pivot_z: '0, radius_x: '0, radius_z: '0, ref_pitch: '0,
                max_delta: 18'd51472, negate_pitch: 1'b0, min_radius: 23'd3277};
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{pos_x: out_tdata[23:0], pos_y: out_tdata[47:24], pos_z: out_tdata[71:48],
                pitch: out_tdata[90:72], ok: out_tdata[91]};
        if (arc_queue.size() == 0) begin
          $display("%0t: result with no request outstanding", $time);
          errors++;
        end else begin
          want = arc_queue.pop_front();
          if (got.pos_x != want.pos_x) report("pos_x", got.pos_x, want.pos_x);
          if (got.pos_y != want.pos_y) report("pos_y", got.pos_y, want.pos_y);
          if (got.pos_z != want.pos_z) report("pos_z", got.pos_z, want.pos_z);
          if (got.pitch != want.pitch) report("out_pitch", got.pitch, want.pitch);
          if (got.ok != want.ok) report("valid_res", got.ok, want.ok);
        end
      end
      if (in_tvalid && in_tready) arc_queue.push_back(predict_arc(in_tdata));
      if (cfg_we) begin
        case (reg_idx_t'(cfg_addr))
          REG_PIVOT_X:    regs.pivot_x <= cfg_wdata;
          REG_PIVOT_Z:    regs.pivot_z <= cfg_wdata;
          REG_RADIUS_X:   regs.radius_x <= cfg_wdata;
          REG_RADIUS_Z:   regs.radius_z <= cfg_wdata;
          REG_REF_PITCH:  regs.ref_pitch <= cfg_wdata[18:0];
          REG_MAX_DELTA:  regs.max_delta <= cfg_wdata[17:0];
          REG_NEGATE:     regs.negate_pitch <= cfg_wdata[0];
          REG_MIN_RADIUS: regs.min_radius <= cfg_wdata[22:0];
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// File: tb/pivot_arc_target_from_pitch_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pivot_arc_target_from_pitch_unit_test: top of the arc unit testbench
// Walks the unit through a series of register settings, from reset values
// and extremes to random ones, sending directed and random pitch requests
// with random gaps and output stalls; the checker judges every result.
// ----------------------------------------------------------------------------
`default_nettype none
module pivot_arc_target_from_pitch_unit_test;
  import patp_pkg::*;

  localparam int CycleLimit = 500000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [87:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [23:0] cfg_wdata;
  int          pending;
  int          errors;
  int          cycles = 0;
  bit          calm = 1'b0;

  always #5 clk = ~clk;

  pivot_arc_target_from_pitch_unit uut (.*);

  pivot_arc_target_from_pitch_unit_check checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("pivot_arc_target_from_pitch_unit test failed");
      $finish;
    end
  end

  initial begin
    out_tready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input logic [23:0] px, pz, rx, rz, rp, md, ng, mr);
    write_reg(REG_PIVOT_X, px);
    write_reg(REG_PIVOT_Z, pz);
    write_reg(REG_RADIUS_X, rx);
    write_reg(REG_RADIUS_Z, rz);
    write_reg(REG_REF_PITCH, rp);
    write_reg(REG_MAX_DELTA, md);
    write_reg(REG_NEGATE, ng);
    write_reg(REG_MIN_RADIUS, mr);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic send(input logic [18:0] nom, off, input logic [23:0] ty, boff);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, boff, ty, off, nom};
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
  endtask

  function automatic logic [18:0] rand_pitch();
    case ($urandom_range(0, 2))
      0: return 19'($urandom);
      1: return 19'($signed($urandom_range(0, 411774)) - 205887);
      default: return 19'($signed($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  function automatic logic [23:0] rand_len(input bit wide);
    if (wide) return 24'($urandom);
    return 24'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
  endfunction

  task automatic send_random(input int n);
    repeat (n) send(rand_pitch(), rand_pitch(), rand_len($urandom_range(0, 3) == 0),
                    rand_len($urandom_range(0, 3) == 0));
  endtask

  task automatic send_directed;
    send(19'h40000, 19'h40000, 24'h7FFFFF, 24'h7FFFFF);
    send(19'h3FFFF, 19'h3FFFF, 24'h800000, 24'h800000);
    send(19'd205887, 19'd0, 24'h7FFFFF, 24'h800000);
    send(-19'sd205887, 19'd0, 24'd0, 24'd0);
    send(19'd205888, 19'd0, 24'h000001, 24'hFFFFFF);
    send(19'd0, 19'd0, 24'h123456, 24'h000100);
    send(19'd102944, 19'd102944, 24'h7FFFFF, 24'h000001);
    send(-19'sd102944, -19'sd102944, 24'h800000, 24'hFFFFFF);
    send(19'd51472, -19'sd1000, 24'h010000, 24'h010000);
    send(19'h3FFFF, 19'h00001, 24'h0, 24'h0);
    send(19'h40000, 19'h3FFFF, 24'hFFFFFF, 24'h000000);
    send(19'd150000, 19'd150000, 24'h400000, 24'h400000);
    send(-19'sd150000, -19'sd150000, 24'hC00000, 24'hC00000);
    send(19'd300, -19'sd300, 24'h0, 24'h7FFFFF);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_addr <= REG_PIVOT_X;
    cfg_wdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: zero radius below the default minimum
    send_directed();
    send_random(40);
    drain();

    write_all(24'h010000, 24'hFF0000, 24'h020000, 24'h008000, 24'd0, 24'd51472,
              24'd0, 24'd3277);
    send_directed();
    send_random(100);
    drain();

    write_all(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'd205887, 24'h3FFFF,
              24'd1, 24'd0);
    send_directed();
    send_random(100);
    drain();

    write_all(24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h7CD41, 24'd0,
              24'd0, 24'h7FFFFF);
    send_random(60);
    drain();

    // zero radius with zero minimum lands on the pivot
    write_all(24'h123456, 24'hABCDEF, 24'd0, 24'd0, 24'h40000, 24'd205887, 24'd1, 24'd0);
    send_directed();
    send_random(60);
    drain();

    // radius exactly at the minimum, then one below
    write_all(24'h000000, 24'h000000, 24'h030000, 24'h040000, 24'd1000, 24'd102944,
              24'd0, 24'h050000);
    send_random(40);
    drain();
    write_reg(REG_MIN_RADIUS, 24'h050001);
    send_random(30);
    drain();

    repeat (6) begin
      write_all(rand_len($urandom_range(0, 1)), rand_len($urandom_range(0, 1)),
                rand_len($urandom_range(0, 1)), rand_len($urandom_range(0, 1)),
                24'(rand_pitch()), 24'($urandom_range(0, 262143)),
                24'($urandom_range(0, 1)),
                24'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 70000)));
      send_random(85);
      drain();
    end

    calm = 1'b1;
    write_all(24'h001000, 24'hFFF000, 24'h018000, 24'hFE8000, 24'hFFF00, 24'd80000,
              24'd1, 24'd100);
    send_random(100);
    drain();

    if (errors == 0) begin
      $display("pivot_arc_target_from_pitch_unit test passed");
    end else begin
      $display("pivot_arc_target_from_pitch_unit test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
rtl/core/patp_pkg.sv
rtl/core/patp_front.sv
rtl/core/patp_cordic.sv
rtl/core/pivot_arc_target_from_pitch_unit.sv
tb/pivot_arc_target_from_pitch_unit_check.sv
tb/pivot_arc_target_from_pitch_unit_test.sv
